FILE: rtl/tlfh_pkg.sv
// ----------------------------------------------------------------------------
// tlfh_pkg
// shared types and constants for the thermistor linearizer with fan hysteresis
// ----------------------------------------------------------------------------
package tlfh_pkg;

  localparam int DEFAULT_TABLE_DEPTH = 32;

  // field widths
  localparam int ADC_W   = 10;
  localparam int IDX_W   = 5;
  localparam int TEMP_W  = 11;
  localparam int CNT_W   = 6;
  localparam int CFG_A_W = 2;

  // stream widths, padded to whole bytes
  localparam int S_DATA_W = 32;
  localparam int M_DATA_W = 16;

  // register reset values
  localparam logic [TEMP_W-1:0] FAN_ON_RST  = TEMP_W'(500);
  localparam logic [TEMP_W-1:0] FAN_OFF_RST = TEMP_W'(480);
  localparam logic [CNT_W-1:0]  ENTRIES_RST = CNT_W'(32);

  // temperature = (i*3+25)*10 + frac = i*30 + 250 + frac
  localparam int TEMP_STEP  = 30;
  localparam int TEMP_BASE  = 250;
  localparam int FRAC_SCALE = 30;
  localparam int TEMP_MAX   = 2047;

  // fraction divider: numerator (hi-s)*30, quotient at most 30
  localparam int NUM_W   = 15;
  localparam int QUO_W   = 5;
  localparam int QCNT_W  = $clog2(QUO_W);

  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_LOAD   = 1'b1
  } kind_e;

  typedef enum logic [CFG_A_W-1:0] {
    CFG_FAN_ON_ABOVE  = 2'd0,
    CFG_FAN_OFF_BELOW = 2'd1,
    CFG_ENTRIES_USED  = 2'd2
  } cfg_idx_e;

  // controller to datapath
  typedef struct packed {
    logic start;
    logic load_wr;
    logic search;
    logic mul;
    logic div_step;
    logic out_load;
  } tlfh_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic found;
    logic div_last;
    logic out_free;
  } tlfh_sts_t;

endpackage

FILE: rtl/tlfh_ctrl.sv
// ----------------------------------------------------------------------------
// tlfh_ctrl
// sequencer for table scan, fraction divide and result handoff
// ----------------------------------------------------------------------------
module tlfh_ctrl
  import tlfh_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_kind_i,
  output logic      in_ready_o,
  output tlfh_cmd_t cmd_o,
  input  tlfh_sts_t sts_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_MUL,
    S_DIV,
    S_FIN
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_ready_o && in_valid_i;

  always_comb begin
    cmd_o          = '0;
    cmd_o.start    = accept && (kind_e'(in_kind_i) == KIND_SAMPLE);
    cmd_o.load_wr  = accept && (kind_e'(in_kind_i) == KIND_LOAD);
    cmd_o.search   = (state_q == S_SEARCH);
    cmd_o.mul      = (state_q == S_MUL);
    cmd_o.div_step = (state_q == S_DIV);
    cmd_o.out_load = (state_q == S_FIN) && sts_i.out_free;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_o.start) state_d = S_SEARCH;
      end
      S_SEARCH: begin
        if (sts_i.found) state_d = S_MUL;
      end
      S_MUL: begin
        state_d = S_DIV;
      end
      S_DIV: begin
        if (sts_i.div_last) state_d = S_FIN;
      end
      S_FIN: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/tlfh_datapath.sv
// ----------------------------------------------------------------------------
// tlfh_datapath
// calibration table, scan registers, fraction divider, fan flag, output beat
// ----------------------------------------------------------------------------
module tlfh_datapath
  import tlfh_pkg::*;
#(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tlfh_cmd_t           cmd_i,
  output tlfh_sts_t           sts_o,
  input  logic                cfg_we_i,
  input  logic [CFG_A_W-1:0]  cfg_addr_i,
  input  logic [TEMP_W-1:0]   cfg_wdata_i,
  input  logic [ADC_W-1:0]    adc_sample_i,
  input  logic [IDX_W-1:0]    entry_index_i,
  input  logic [ADC_W-1:0]    entry_value_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [TEMP_W-1:0]   temperature_tenths_o,
  output logic                fan_command_o,
  output logic                out_of_range_o
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int NW = $clog2(TABLE_DEPTH + 1);
  localparam int TW = (NW + 6 > 12) ? NW + 6 : 12;

  // configuration
  logic [TEMP_W-1:0] fan_on_above_q, fan_off_below_q;
  logic [CNT_W-1:0]  entries_used_q;

  // calibration table
  logic [ADC_W-1:0]  table_mem [TABLE_DEPTH];
  logic [ADC_W-1:0]  rdata_q;

  // scan
  logic [NW-1:0]     n_used;
  logic [NW-1:0]     k_q, j_q, i_q;
  logic              dv_q;
  logic [ADC_W-1:0]  smp_q, prev_q, hi_q, lo_q, seff_q;
  logic              zero_q, oor_q;
  logic              hit_le;

  // divider
  logic [NUM_W-1:0]  rem_q, den_sh_q;
  logic [QUO_W-1:0]  quo_q;
  logic [QCNT_W-1:0] qcnt_q;
  logic [ADC_W-1:0]  num_diff, den_diff;
  logic              rem_ge;

  // result
  logic [TW-1:0]     temp_wide;
  logic [TEMP_W-1:0] temp_sat;
  logic              fan_q, fan_d;
  logic              out_valid_q;
  logic [TEMP_W-1:0] out_temp_q;
  logic              out_fan_q, out_oor_q;

  // ---------------- configuration registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fan_on_above_q  <= FAN_ON_RST;
      fan_off_below_q <= FAN_OFF_RST;
      entries_used_q  <= ENTRIES_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_FAN_ON_ABOVE:  fan_on_above_q  <= cfg_wdata_i;
        CFG_FAN_OFF_BELOW: fan_off_below_q <= cfg_wdata_i;
        CFG_ENTRIES_USED:  entries_used_q  <= cfg_wdata_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (entries_used_q < CNT_W'(2)) begin
      n_used = NW'(2);
    end else if (int'(entries_used_q) > TABLE_DEPTH) begin
      n_used = NW'(TABLE_DEPTH);
    end else begin
      n_used = NW'(entries_used_q);
    end
  end

  // ---------------- table memory ----------------
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_wr && (int'(entry_index_i) < TABLE_DEPTH)) begin
      table_mem[IW'(entry_index_i)] <= entry_value_i;
    end
    if (cmd_i.search) begin
      rdata_q <= table_mem[k_q[IW-1:0]];
    end
  end

  // ---------------- scan ----------------
  // one read issued per cycle, compare runs one entry behind
  assign hit_le      = (rdata_q <= smp_q);
  assign sts_o.found = cmd_i.search && dv_q && (hit_le || (j_q == n_used - NW'(1)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q <= 1'b0;
    end else if (cmd_i.start) begin
      dv_q <= 1'b0;
    end else if (cmd_i.search) begin
      dv_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      smp_q <= adc_sample_i;
      k_q   <= '0;
    end
    if (cmd_i.search) begin
      k_q <= k_q + NW'(1);
      j_q <= k_q;
      if (dv_q) prev_q <= rdata_q;
    end
    if (sts_o.found) begin
      hi_q <= prev_q;
      lo_q <= rdata_q;
      if (hit_le) begin
        if (j_q == '0) begin
          // at or above entry 0: fraction is zero
          i_q    <= NW'(1);
          zero_q <= 1'b1;
          oor_q  <= (smp_q > rdata_q);
          seff_q <= rdata_q;
        end else begin
          i_q    <= j_q;
          zero_q <= 1'b0;
          oor_q  <= 1'b0;
          seff_q <= smp_q;
        end
      end else begin
        // below every entry in use: clamp to the last one
        i_q    <= j_q;
        zero_q <= !(prev_q > rdata_q);
        oor_q  <= 1'b1;
        seff_q <= rdata_q;
      end
    end
  end

  // ---------------- fraction divider ----------------
  assign num_diff = hi_q - seff_q;
  assign den_diff = hi_q - lo_q;
  assign rem_ge   = (rem_q >= den_sh_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      rem_q    <= NUM_W'(num_diff) * NUM_W'(FRAC_SCALE);
      den_sh_q <= NUM_W'(den_diff) << (QUO_W - 1);
      quo_q    <= '0;
      qcnt_q   <= '0;
    end else if (cmd_i.div_step) begin
      if (rem_ge) rem_q <= rem_q - den_sh_q;
      quo_q    <= {quo_q[QUO_W-2:0], rem_ge};
      den_sh_q <= den_sh_q >> 1;
      qcnt_q   <= qcnt_q + QCNT_W'(1);
    end
  end

  assign sts_o.div_last = cmd_i.div_step && (qcnt_q == QCNT_W'(QUO_W - 1));

  // ---------------- temperature and fan ----------------
  assign temp_wide = TW'(i_q) * TW'(TEMP_STEP) + TW'(TEMP_BASE)
                   + (zero_q ? TW'(0) : TW'(quo_q));
  assign temp_sat  = (temp_wide > TW'(TEMP_MAX)) ? TEMP_W'(TEMP_MAX) : temp_wide[TEMP_W-1:0];

  always_comb begin
    fan_d = fan_q;
    if (temp_sat > fan_on_above_q && !fan_q) begin
      fan_d = 1'b1;
    end else if (temp_sat < fan_off_below_q && fan_q) begin
      fan_d = 1'b0;
    end
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fan_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.out_load) begin
        fan_q       <= fan_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_temp_q <= temp_sat;
      out_fan_q  <= fan_d;
      out_oor_q  <= oor_q;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign temperature_tenths_o = out_temp_q;
  assign fan_command_o        = out_fan_q;
  assign out_of_range_o       = out_oor_q;

  // ---------------- assertions ----------------
  a_scan_in_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.search && dv_q) |-> (j_q < n_used))
    else $error("scan compared an entry beyond the entries in use");

  a_quo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.out_load && !zero_q) |-> (quo_q <= QUO_W'(FRAC_SCALE)))
    else $error("interpolation fraction above full step");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over a beat not yet taken");

endmodule

FILE: rtl/thermistor_linearize_fan_hysteresis_top.sv
// ----------------------------------------------------------------------------
// thermistor_linearize_fan_hysteresis_top
// thermistor reading to temperature in tenths, with fan on/off hysteresis
// ----------------------------------------------------------------------------
// A load beat (tuser = 1) writes one entry of the calibration table. A sample
// beat (tuser = 0) scans the table from entry 0 for the first entry not above
// the reading, interpolates between that entry and the one before it, and
// updates the fan flag; it gives one result beat. The scan reads one table
// entry per cycle through the single read port, and the fraction comes from a
// 5-step restoring divider. A sample holds the block until the scan stops at
// a hit or at the last entry in use and its result is loaded, which waits
// while the previous result beat is not yet taken on m_axis_tready_i. The
// output register lets the next beat be accepted while a result is pending.
// Table entries read before they were ever loaded give undefined results.
// Configuration writes (index 0 fan_on_above, 1 fan_off_below, 2
// entries_used) are always ready and must be made while the block is idle.
// ----------------------------------------------------------------------------
module thermistor_linearize_fan_hysteresis_top
  import tlfh_pkg::*;
#(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CFG_A_W-1:0]  cfg_addr_i,
  input  logic [TEMP_W-1:0]   cfg_wdata_i,
  // input stream
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // [9:0] adc_sample, [14:10] entry_index, [24:15] entry_value, rest zero
  input  logic [S_DATA_W-1:0] s_axis_tdata_i,
  // [0] kind
  input  logic                s_axis_tuser_i,
  // result stream
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // [10:0] temperature_tenths, [11] fan_command, [12] out_of_range, rest zero
  output logic [M_DATA_W-1:0] m_axis_tdata_o
);

  tlfh_cmd_t         cmd;
  tlfh_sts_t         sts;
  logic [TEMP_W-1:0] temp;
  logic              fan_cmd;
  logic              oor;

  // register writes never stall
  assign cfg_ready_o = 1'b1;

  tlfh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_kind_i  (s_axis_tuser_i),
    .in_ready_o (s_axis_tready_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  tlfh_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .sts_o                (sts),
    .cfg_we_i             (cfg_valid_i && cfg_ready_o),
    .cfg_addr_i           (cfg_addr_i),
    .cfg_wdata_i          (cfg_wdata_i),
    .adc_sample_i         (s_axis_tdata_i[ADC_W-1:0]),
    .entry_index_i        (s_axis_tdata_i[ADC_W +: IDX_W]),
    .entry_value_i        (s_axis_tdata_i[ADC_W+IDX_W +: ADC_W]),
    .out_valid_o          (m_axis_tvalid_o),
    .out_ready_i          (m_axis_tready_i),
    .temperature_tenths_o (temp),
    .fan_command_o        (fan_cmd),
    .out_of_range_o       (oor)
  );

  // pack the result beat, padding bits held at zero
  assign m_axis_tdata_o = {{(M_DATA_W - TEMP_W - 2){1'b0}}, oor, fan_cmd, temp};

endmodule
